// File: sv/ptm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ptm_pkg
// Shared types, constants and the control program of the periodic timer
// multiplexer.
// ============================================================================
package ptm_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 32;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int ID_W       = 32;
    localparam int FIELD_W    = 32;
    localparam int PC_W       = 4;

    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_DEL  = 2'd1,
        REQ_TICK = 2'd2
    } req_code_t;

    typedef enum logic [2:0] {
        KIND_FIRED    = 3'd0,
        KIND_ADDED    = 3'd1,
        KIND_REMOVED  = 3'd2,
        KIND_FULL     = 3'd3,
        KIND_NOTFOUND = 3'd4,
        KIND_TICKDONE = 3'd5
    } kind_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [31:0] period_ms;
        logic [31:0] target_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] timer_id;
        logic [31:0] next_delta_ms;
        logic        delta_valid;
        logic        last_result;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_FETCH    = 4'd1,
        OP_ADD      = 4'd2,
        OP_DEL_SCAN = 4'd3,
        OP_DEL_END  = 4'd4,
        OP_EXP_SCAN = 4'd5,
        OP_SEL_SCAN = 4'd6,
        OP_FIRE     = 4'd7,
        OP_MIN_SCAN = 4'd8,
        OP_FINAL    = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        WAIT_NONE = 2'd0,
        WAIT_IN   = 2'd1,
        WAIT_SCAN = 2'd2,
        WAIT_OUT  = 2'd3
    } wait_t;

    typedef enum logic [1:0] {
        BR_NEXT      = 2'd0,
        BR_ALWAYS    = 2'd1,
        BR_PEND_NONE = 2'd2,
        BR_DISPATCH  = 2'd3
    } br_t;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_FETCH = 4'd0;
    localparam pc_t STEP_ADD   = 4'd1;
    localparam pc_t STEP_DSCAN = 4'd2;
    localparam pc_t STEP_DEND  = 4'd3;
    localparam pc_t STEP_ESCAN = 4'd4;
    localparam pc_t STEP_SELT  = 4'd5;
    localparam pc_t STEP_SSCAN = 4'd6;
    localparam pc_t STEP_FIRE  = 4'd7;
    localparam pc_t STEP_MIN   = 4'd8;
    localparam pc_t STEP_FINAL = 4'd9;

    typedef struct packed {
        op_t   op;
        wait_t wt;
        br_t   br;
        pc_t   target;
    } ctl_t;

    typedef struct packed {
        logic scan_done;
        logic pend_none;
    } dp_stat_t;

    // control store: one word per step
    function automatic ctl_t prog_rom(input pc_t pc);
        ctl_t w;
        case (pc)
            STEP_FETCH: w = '{OP_FETCH,    WAIT_IN,   BR_DISPATCH,  STEP_FETCH};
            STEP_ADD:   w = '{OP_ADD,      WAIT_NONE, BR_ALWAYS,    STEP_MIN};
            STEP_DSCAN: w = '{OP_DEL_SCAN, WAIT_SCAN, BR_NEXT,      STEP_FETCH};
            STEP_DEND:  w = '{OP_DEL_END,  WAIT_NONE, BR_ALWAYS,    STEP_MIN};
            STEP_ESCAN: w = '{OP_EXP_SCAN, WAIT_SCAN, BR_NEXT,      STEP_FETCH};
            STEP_SELT:  w = '{OP_NOP,      WAIT_NONE, BR_PEND_NONE, STEP_MIN};
            STEP_SSCAN: w = '{OP_SEL_SCAN, WAIT_SCAN, BR_NEXT,      STEP_FETCH};
            STEP_FIRE:  w = '{OP_FIRE,     WAIT_OUT,  BR_ALWAYS,    STEP_SELT};
            STEP_MIN:   w = '{OP_MIN_SCAN, WAIT_SCAN, BR_NEXT,      STEP_FETCH};
            STEP_FINAL: w = '{OP_FINAL,    WAIT_OUT,  BR_ALWAYS,    STEP_FETCH};
            default:    w = '{OP_NOP,      WAIT_NONE, BR_ALWAYS,    STEP_FETCH};
        endcase
        return w;
    endfunction

    function automatic pc_t dispatch_pc(input logic [1:0] code);
        pc_t p;
        case (req_code_t'(code))
            REQ_ADD:  p = STEP_ADD;
            REQ_DEL:  p = STEP_DSCAN;
            REQ_TICK: p = STEP_ESCAN;
            default:  p = STEP_FETCH;
        endcase
        return p;
    endfunction

endpackage

// File: sv/ptm_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// ptm_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module ptm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/ptm_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// ptm_seq
// Step counter and control store; holds on wait conditions, branches on
// request type and pending status.
// ============================================================================
module ptm_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  ptm_pkg::dp_stat_t stat,
    input  logic              req_valid,
    input  logic [1:0]        req_type,
    input  logic              out_free,
    output ptm_pkg::ctl_t     ctl
);

    ptm_pkg::pc_t pc_reg;
    ptm_pkg::pc_t pc_next;
    logic         hold;

    assign ctl = ptm_pkg::prog_rom(pc_reg);

    always_comb
    begin
        case (ctl.wt)
            ptm_pkg::WAIT_IN:   hold = !req_valid;
            ptm_pkg::WAIT_SCAN: hold = !stat.scan_done;
            ptm_pkg::WAIT_OUT:  hold = !out_free;
            default:            hold = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            case (ctl.br)
                ptm_pkg::BR_NEXT:      pc_next = pc_reg + ptm_pkg::pc_t'(1);
                ptm_pkg::BR_ALWAYS:    pc_next = ctl.target;
                ptm_pkg::BR_PEND_NONE:
                    pc_next = stat.pend_none ? ctl.target : pc_reg + ptm_pkg::pc_t'(1);
                ptm_pkg::BR_DISPATCH:  pc_next = ptm_pkg::dispatch_pc(req_type);
                default:               pc_next = ptm_pkg::STEP_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ptm_pkg::STEP_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: sv/ptm_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// ptm_dp
// Timer table datapath: slot RAMs, live and pending bits, scan counter and
// the accumulators driven by the control word.
// ============================================================================
module ptm_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  ptm_pkg::ctl_t     ctl,
    input  logic              req_valid,
    input  ptm_pkg::req_t     req,
    input  logic              out_free,
    output ptm_pkg::dp_stat_t stat,
    output logic              emit,
    output ptm_pkg::rsp_t     emit_rsp
);

    localparam int NT = ptm_pkg::NUM_TIMERS;
    localparam int TB = ptm_pkg::TIME_BITS;
    localparam int IW = ptm_pkg::IDX_W;
    localparam int CW = ptm_pkg::CNT_W;
    localparam int DW = ptm_pkg::ID_W;
    localparam int FW = ptm_pkg::FIELD_W;

    ptm_pkg::req_t  req_reg,        req_next;
    logic [NT-1:0]  live_reg,       live_next;
    logic [NT-1:0]  pend_reg,       pend_next;
    logic [DW-1:0]  next_id_reg,    next_id_next;
    logic [CW-1:0]  scan_reg,       scan_next;
    logic           rd_vld_reg,     rd_vld_next;
    logic [IW-1:0]  rd_idx_reg,     rd_idx_next;
    ptm_pkg::kind_t kind_reg,       kind_next;
    logic [DW-1:0]  id_reg,         id_next;
    logic           hit_reg,        hit_next;
    logic [IW-1:0]  hit_idx_reg,    hit_idx_next;
    logic           best_found_reg, best_found_next;
    logic [DW-1:0]  best_id_reg,    best_id_next;
    logic [IW-1:0]  best_idx_reg,   best_idx_next;
    logic           any_reg,        any_next;
    logic [TB-1:0]  min_reg,        min_next;

    logic          we_id, we_per, we_last;
    logic [IW-1:0] waddr;
    logic [DW-1:0] id_rd;
    logic [TB-1:0] per_rd, last_rd;
    logic [TB-1:0] now_t, per_t, per_wr;
    logic [TB-1:0] elapsed, togo;
    logic          expired, rd_live, rd_pend;
    logic          scanning, scan_done, scan_first;
    logic          free_any;
    logic [IW-1:0] free_idx;

    assign now_t   = req_reg.now_ms[TB-1:0];
    assign per_t   = req_reg.period_ms[TB-1:0];
    assign per_wr  = (per_t == '0) ? TB'(1) : per_t;
    assign elapsed = now_t - last_rd;
    assign expired = elapsed >= per_rd;
    assign togo    = per_rd - elapsed;
    assign rd_live = live_reg[rd_idx_reg];
    assign rd_pend = pend_reg[rd_idx_reg];

    assign scanning   = ctl.op inside {ptm_pkg::OP_DEL_SCAN, ptm_pkg::OP_EXP_SCAN,
                                       ptm_pkg::OP_SEL_SCAN, ptm_pkg::OP_MIN_SCAN};
    assign scan_done  = scan_reg == CW'(NT);
    assign scan_first = scan_reg == '0;

    assign stat.scan_done = scan_done;
    assign stat.pend_none = ~|pend_reg;

    // lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NT - 1; i >= 0; i--)
        begin
            if (!live_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    ptm_ram #(.WIDTH(DW), .DEPTH(NT)) u_id_ram (
        .clk   (clk),
        .we    (we_id),
        .waddr (waddr),
        .wdata (next_id_reg),
        .raddr (scan_reg[IW-1:0]),
        .rdata (id_rd)
    );

    ptm_ram #(.WIDTH(TB), .DEPTH(NT)) u_per_ram (
        .clk   (clk),
        .we    (we_per),
        .waddr (waddr),
        .wdata (per_wr),
        .raddr (scan_reg[IW-1:0]),
        .rdata (per_rd)
    );

    ptm_ram #(.WIDTH(TB), .DEPTH(NT)) u_last_ram (
        .clk   (clk),
        .we    (we_last),
        .waddr (waddr),
        .wdata (now_t),
        .raddr (scan_reg[IW-1:0]),
        .rdata (last_rd)
    );

    always_comb
    begin
        req_next        = req_reg;
        live_next       = live_reg;
        pend_next       = pend_reg;
        next_id_next    = next_id_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        best_found_next = best_found_reg;
        best_id_next    = best_id_reg;
        best_idx_next   = best_idx_reg;
        any_next        = any_reg;
        min_next        = min_reg;
        we_id           = 1'b0;
        we_per          = 1'b0;
        we_last         = 1'b0;
        waddr           = best_idx_reg;
        emit            = 1'b0;
        emit_rsp        = '0;

        if (scanning && !scan_done)
        begin
            scan_next   = scan_reg + CW'(1);
            rd_vld_next = 1'b1;
            rd_idx_next = scan_reg[IW-1:0];
        end
        else
        begin
            scan_next   = '0;
            rd_vld_next = 1'b0;
            rd_idx_next = rd_idx_reg;
        end

        case (ctl.op)
            ptm_pkg::OP_FETCH:
            begin
                if (req_valid)
                begin
                    req_next  = req;
                    kind_next = ptm_pkg::KIND_TICKDONE;
                    id_next   = '0;
                end
            end
            ptm_pkg::OP_ADD:
            begin
                if (free_any)
                begin
                    live_next[free_idx] = 1'b1;
                    waddr        = free_idx;
                    we_id        = 1'b1;
                    we_per       = 1'b1;
                    we_last      = 1'b1;
                    kind_next    = ptm_pkg::KIND_ADDED;
                    id_next      = next_id_reg;
                    next_id_next = next_id_reg + DW'(1);
                end
                else
                begin
                    kind_next = ptm_pkg::KIND_FULL;
                    id_next   = '0;
                end
            end
            ptm_pkg::OP_DEL_SCAN:
            begin
                if (scan_first)
                begin
                    hit_next = 1'b0;
                end
                else if (rd_vld_reg && rd_live && !hit_reg && id_rd == req_reg.target_id)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = rd_idx_reg;
                end
            end
            ptm_pkg::OP_DEL_END:
            begin
                if (hit_reg)
                begin
                    live_next[hit_idx_reg] = 1'b0;
                    kind_next = ptm_pkg::KIND_REMOVED;
                    id_next   = req_reg.target_id;
                end
                else
                begin
                    kind_next = ptm_pkg::KIND_NOTFOUND;
                    id_next   = '0;
                end
            end
            ptm_pkg::OP_EXP_SCAN:
            begin
                if (scan_first)
                begin
                    pend_next = '0;
                end
                else if (rd_vld_reg && rd_live && expired)
                begin
                    pend_next[rd_idx_reg] = 1'b1;
                end
            end
            ptm_pkg::OP_SEL_SCAN:
            begin
                if (scan_first)
                begin
                    best_found_next = 1'b0;
                end
                else if (rd_vld_reg && rd_pend && (!best_found_reg || id_rd < best_id_reg))
                begin
                    best_found_next = 1'b1;
                    best_id_next    = id_rd;
                    best_idx_next   = rd_idx_reg;
                end
            end
            ptm_pkg::OP_FIRE:
            begin
                if (out_free)
                begin
                    we_last                 = 1'b1;
                    pend_next[best_idx_reg] = 1'b0;
                    emit                    = 1'b1;
                    emit_rsp.result_kind    = ptm_pkg::KIND_FIRED;
                    emit_rsp.timer_id       = best_id_reg;
                end
            end
            ptm_pkg::OP_MIN_SCAN:
            begin
                if (scan_first)
                begin
                    any_next = 1'b0;
                end
                else if (rd_vld_reg && rd_live && (!any_reg || togo < min_reg))
                begin
                    any_next = 1'b1;
                    min_next = togo;
                end
            end
            ptm_pkg::OP_FINAL:
            begin
                if (out_free)
                begin
                    emit                   = 1'b1;
                    emit_rsp.result_kind   = kind_reg;
                    emit_rsp.timer_id      = id_reg;
                    emit_rsp.next_delta_ms = any_reg ? FW'(min_reg) : '0;
                    emit_rsp.delta_valid   = any_reg;
                    emit_rsp.last_result   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg       <= '0;
            pend_reg       <= '0;
            next_id_reg    <= DW'(1);
            scan_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            best_found_reg <= 1'b0;
            any_reg        <= 1'b0;
            kind_reg       <= ptm_pkg::KIND_TICKDONE;
        end
        else
        begin
            live_reg       <= live_next;
            pend_reg       <= pend_next;
            next_id_reg    <= next_id_next;
            scan_reg       <= scan_next;
            rd_vld_reg     <= rd_vld_next;
            hit_reg        <= hit_next;
            best_found_reg <= best_found_next;
            any_reg        <= any_next;
            kind_reg       <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rd_idx_reg   <= rd_idx_next;
        id_reg       <= id_next;
        hit_idx_reg  <= hit_idx_next;
        best_id_reg  <= best_id_next;
        best_idx_reg <= best_idx_next;
        min_reg      <= min_next;
    end

endmodule

// File: sv/periodic_timer_multiplexer_core.sv
`timescale 1ns / 1ps
// ============================================================================
// periodic_timer_multiplexer_core
// Table of periodic timers with add, delete and tick requests.
// ============================================================================
// Request channel req_valid / req_stall / req: one beat is an add, delete or
// tick request; request code 3 is dropped without a result.
// Response channel rsp_valid / rsp_stall / rsp: one beat per result; the last
// beat of a request carries last_result.
// A microcoded sequencer walks the slot RAMs one entry per cycle; the scans
// set the pace. Per request:
//   add    : one scan for the minimum remaining time
//   delete : search scan plus minimum scan
//   tick   : expiry scan, one id selection scan per fired timer, minimum
//            scan
// Results leave through an output register; the next request is taken while
// the final result of the previous one still waits there.
// A stalled response holds its beat and halts the sequencer at the next
// result it wants to send.
// Reset clears all timers and restarts ids at 1; no clearing pass is needed.
// ============================================================================
module periodic_timer_multiplexer_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ptm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ptm_pkg::rsp_t rsp
);

    ptm_pkg::ctl_t     ctl;
    ptm_pkg::dp_stat_t stat;
    logic              emit;
    ptm_pkg::rsp_t     emit_rsp;
    logic              out_free;
    logic              rsp_valid_reg, rsp_valid_next;
    ptm_pkg::rsp_t     rsp_reg,       rsp_next;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = ctl.op != ptm_pkg::OP_FETCH;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ptm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .out_free  (out_free),
        .ctl       (ctl)
    );

    ptm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req_valid (req_valid),
        .req       (req),
        .out_free  (out_free),
        .stat      (stat),
        .emit      (emit),
        .emit_rsp  (emit_rsp)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (emit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit_rsp;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

// File: sv/ptm_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ptm_checker
// Port-level checks of the response channel.
// ============================================================================
module ptm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input ptm_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed under stall");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind == ptm_pkg::KIND_FIRED
            |-> !rsp.last_result && !rsp.delta_valid && rsp.next_delta_ms == '0)
        else $error("fired beat marked last or carries a delta");

    a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind != ptm_pkg::KIND_FIRED |-> rsp.last_result)
        else $error("closing beat without last mark");

    a_added_live: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind == ptm_pkg::KIND_ADDED |-> rsp.delta_valid)
        else $error("added beat without a live timer");

    a_delta_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.delta_valid |-> rsp.next_delta_ms == '0)
        else $error("delta set without a live timer");

endmodule

bind periodic_timer_multiplexer_core ptm_checker u_ptm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
